// ===== hw/rtl/apsp_pkg.sv =====
// Shared constants, memory word types and saturating add for the shortest-path block.
package apsp_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int VTX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = VTX_W + 1;
   localparam int ADDR_W       = 2 * VTX_W;
   localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
   localparam int DIST_W       = 32;
   localparam int FUNC_W       = 2;

   localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FN_RUN   = 2'd1;
   localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

   localparam logic [DIST_W-1:0] SAT_HI = {1'b0, {(DIST_W-1){1'b1}}};
   localparam logic [DIST_W-1:0] SAT_LO = {1'b1, {(DIST_W-1){1'b0}}};

   typedef struct packed {
      logic [DIST_W-1:0] cost;
      logic              reach;
   } dist_word_type;

   typedef struct packed {
      logic [VTX_W-1:0] hop;
      logic             valid;
   } hop_word_type;

   typedef struct packed {
      logic               d_we;
      logic [ADDR_W-1:0]  d_waddr;
      dist_word_type      d_wdata;
      logic               d_re0;
      logic [ADDR_W-1:0]  d_raddr0;
      logic               d_re1;
      logic [ADDR_W-1:0]  d_raddr1;
      logic               h_we;
      logic [ADDR_W-1:0]  h_waddr;
      hop_word_type       h_wdata;
      logic               h_re;
      logic [ADDR_W-1:0]  h_raddr;
   } mem_cmd_type;

   function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
      logic [DIST_W:0] s;
      s = {a[DIST_W-1], a} + {b[DIST_W-1], b};
      if (s[DIST_W] != s[DIST_W-1]) begin
         sat_add = s[DIST_W] ? SAT_LO : SAT_HI;
      end else begin
         sat_add = s[DIST_W-1:0];
      end
   endfunction

endpackage

// ===== hw/rtl/all_pairs_shortest_path.sv =====
// Top level of the all-pairs shortest-path block with next-hop tracking.
//
//   channel | direction | ports                     | transfer
//   req     | in        | req_valid, req_stall, ... | valid && !stall
//   rsp     | out       | rsp_valid, rsp_stall, ... | valid && !stall
//   csr     | in        | csr_wr_en, csr_wr_data    | wr_en
//
// Writes and reads are taken back to back while req_stall is low; read data
// passes from the registered memory port into the output register.
// A run's relaxation loop does one (i,j) pair per cycle on two memory read ports.
// After reset a clearing pass over every memory entry runs with req_stall high.
// A result held by rsp_stall stalls further requests once another read is pending.
module all_pairs_shortest_path (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [apsp_pkg::FUNC_W-1:0]   req_func,
   input  logic [apsp_pkg::VTX_W-1:0]    req_row,
   input  logic [apsp_pkg::VTX_W-1:0]    req_col,
   input  logic signed [apsp_pkg::DIST_W-1:0] req_weight,
   input  logic                          req_edge_present,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_done,
   output logic signed [apsp_pkg::DIST_W-1:0] rsp_distance,
   output logic                          rsp_reachable,
   output logic [apsp_pkg::VTX_W-1:0]    rsp_next_vertex,
   output logic                          rsp_has_next,
   input  logic                          csr_wr_en,
   input  logic [apsp_pkg::CNT_W-1:0]    csr_wr_data
);
   import apsp_pkg::*;

   logic [CNT_W-1:0]  node_count_ff;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_is_done_ff, rsp_is_done_in;
   logic [DIST_W-1:0] rsp_distance_ff, rsp_distance_in;
   logic              rsp_reachable_ff, rsp_reachable_in;
   logic [VTX_W-1:0]  rsp_next_vertex_ff, rsp_next_vertex_in;
   logic              rsp_has_next_ff, rsp_has_next_in;

   logic              accept, acc_write, acc_run, acc_read;
   logic              can_move, load_read, load_done;
   logic              seq_busy, done_req;
   logic [ADDR_W-1:0] host_addr;
   mem_cmd_type       host_cmd, seq_cmd, mem_cmd;
   dist_word_type     d_rd0, d_rd1;
   hop_word_type      h_rd;

   assign can_move  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = seq_busy || (pend_ff && !can_move);
   assign accept    = req_valid && !req_stall;
   assign acc_write = accept && (req_func == FN_WRITE);
   assign acc_run   = accept && (req_func == FN_RUN);
   assign acc_read  = accept && (req_func == FN_READ);
   assign host_addr = {req_row, req_col};

   always_comb begin
      host_cmd               = '0;
      host_cmd.d_we          = acc_write;
      host_cmd.d_waddr       = host_addr;
      host_cmd.d_wdata.cost  = req_weight;
      host_cmd.d_wdata.reach = req_edge_present;
      host_cmd.d_re0         = acc_read;
      host_cmd.d_raddr0      = host_addr;
      host_cmd.h_re          = acc_read;
      host_cmd.h_raddr       = host_addr;
   end

   assign mem_cmd = seq_busy ? seq_cmd : host_cmd;

   apsp_store u_store (
      .clock    (clock),
      .cmd      (mem_cmd),
      .d_rdata0 (d_rd0),
      .d_rdata1 (d_rd1),
      .h_rdata  (h_rd)
   );

   apsp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (acc_run),
      .node_count (node_count_ff),
      .d_rd0      (d_rd0),
      .d_rd1      (d_rd1),
      .h_rd       (h_rd),
      .done_ack   (load_done),
      .cmd        (seq_cmd),
      .busy       (seq_busy),
      .done_req   (done_req)
   );

   assign load_read = pend_ff && can_move;
   assign load_done = done_req && can_move && !pend_ff;
   assign pend_in   = acc_read || (pend_ff && !can_move);

   always_comb begin
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_is_done_in     = rsp_is_done_ff;
      rsp_distance_in    = rsp_distance_ff;
      rsp_reachable_in   = rsp_reachable_ff;
      rsp_next_vertex_in = rsp_next_vertex_ff;
      rsp_has_next_in    = rsp_has_next_ff;
      if (load_read) begin
         rsp_valid_in       = 1'b1;
         rsp_is_done_in     = 1'b0;
         rsp_distance_in    = d_rd0.reach ? d_rd0.cost : '0;
         rsp_reachable_in   = d_rd0.reach;
         rsp_next_vertex_in = h_rd.valid ? h_rd.hop : '0;
         rsp_has_next_in    = h_rd.valid;
      end else if (load_done) begin
         rsp_valid_in       = 1'b1;
         rsp_is_done_in     = 1'b1;
         rsp_distance_in    = '0;
         rsp_reachable_in   = 1'b0;
         rsp_next_vertex_in = '0;
         rsp_has_next_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CNT_W'(MAX_VERTICES);
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_is_done_ff     <= rsp_is_done_in;
      rsp_distance_ff    <= rsp_distance_in;
      rsp_reachable_ff   <= rsp_reachable_in;
      rsp_next_vertex_ff <= rsp_next_vertex_in;
      rsp_has_next_ff    <= rsp_has_next_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_done     = rsp_is_done_ff;
   assign rsp_distance    = rsp_distance_ff;
   assign rsp_reachable   = rsp_reachable_ff;
   assign rsp_next_vertex = rsp_next_vertex_ff;
   assign rsp_has_next    = rsp_has_next_ff;

`ifndef SYNTHESIS
   a_no_pend_in_run: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && seq_busy))
      else $error("read data pending while sequencer owns the memory");

   a_done_lands: assert property (@(posedge clock) disable iff (reset)
      load_done |=> (rsp_valid_ff && rsp_is_done_ff))
      else $error("run completion not placed in output register");

   a_no_rw_same0: assert property (@(posedge clock) disable iff (reset)
      (mem_cmd.d_we && mem_cmd.d_re0) |-> (mem_cmd.d_waddr != mem_cmd.d_raddr0))
      else $error("distance read port 0 collides with write");

   a_no_rw_same1: assert property (@(posedge clock) disable iff (reset)
      (mem_cmd.d_we && mem_cmd.d_re1) |-> (mem_cmd.d_waddr != mem_cmd.d_raddr1))
      else $error("distance read port 1 collides with write");
`endif

endmodule

// ===== hw/rtl/apsp_store.sv =====
// Distance and next-hop memories with registered reads.
module apsp_store (
   input  logic                   clock,
   input  apsp_pkg::mem_cmd_type  cmd,
   output apsp_pkg::dist_word_type d_rdata0,
   output apsp_pkg::dist_word_type d_rdata1,
   output apsp_pkg::hop_word_type  h_rdata
);
   import apsp_pkg::*;

   dist_word_type dist_mem [DEPTH];
   hop_word_type  hop_mem  [DEPTH];

   always_ff @(posedge clock) begin
      if (cmd.d_we) begin
         dist_mem[cmd.d_waddr] <= cmd.d_wdata;
      end
      if (cmd.d_re0) begin
         d_rdata0 <= dist_mem[cmd.d_raddr0];
      end
      if (cmd.d_re1) begin
         d_rdata1 <= dist_mem[cmd.d_raddr1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.h_we) begin
         hop_mem[cmd.h_waddr] <= cmd.h_wdata;
      end
      if (cmd.h_re) begin
         h_rdata <= hop_mem[cmd.h_raddr];
      end
   end

endmodule

// ===== hw/rtl/apsp_seq.sv =====
// Sequencer: clearing pass, next-hop setup and k-i-j relaxation over the memories.
module apsp_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [apsp_pkg::CNT_W-1:0] node_count,
   input  apsp_pkg::dist_word_type d_rd0,
   input  apsp_pkg::dist_word_type d_rd1,
   input  apsp_pkg::hop_word_type  h_rd,
   input  logic                    done_ack,
   output apsp_pkg::mem_cmd_type   cmd,
   output logic                    busy,
   output logic                    done_req
);
   import apsp_pkg::*;

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_INIT_RD = 3'd2;
   localparam logic [2:0] S_INIT_WR = 3'd3;
   localparam logic [2:0] S_HDR     = 3'd4;
   localparam logic [2:0] S_HDR2    = 3'd5;
   localparam logic [2:0] S_LOOP    = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [DIST_W-1:0] ik_dist_ff, ik_dist_in;

   logic [CNT_W-1:0]  n_sat;
   logic [CNT_W-1:0]  i_nxt, j_nxt, k_nxt;
   logic              last_i, last_j, last_k;
   logic [CNT_W-1:0]  row_i, row_k;
   logic [2:0]        row_state;
   logic [DIST_W-1:0] sum;
   logic              upd;

   assign n_sat  = (node_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : node_count;
   assign i_nxt  = i_ff + CNT_W'(1);
   assign j_nxt  = j_ff + CNT_W'(1);
   assign k_nxt  = k_ff + CNT_W'(1);
   assign last_i = (i_nxt == n_ff);
   assign last_j = (j_nxt == n_ff);
   assign last_k = (k_nxt == n_ff);

   // step to the next (k, i) row of the relaxation
   always_comb begin
      row_i     = i_nxt;
      row_k     = k_ff;
      row_state = S_HDR;
      if (last_i) begin
         row_i = '0;
         if (last_k) begin
            row_state = S_DONE;
         end else begin
            row_k = k_nxt;
         end
      end
   end

   assign sum = sat_add(ik_dist_ff, d_rd0.cost);
   assign upd = d_rd0.reach && (!d_rd1.reach || ($signed(sum) < $signed(d_rd1.cost)));

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      ik_dist_in = ik_dist_ff;
      cmd        = '0;
      done_req   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.d_we    = 1'b1;
            cmd.d_waddr = clr_ff;
            cmd.h_we    = 1'b1;
            cmd.h_waddr = clr_ff;
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               n_in     = n_sat;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = (n_sat == '0) ? S_DONE : S_INIT_RD;
            end
         end
         S_INIT_RD: begin
            cmd.d_re0    = 1'b1;
            cmd.d_raddr0 = {i_ff[VTX_W-1:0], j_ff[VTX_W-1:0]};
            state_in     = S_INIT_WR;
         end
         S_INIT_WR: begin
            cmd.h_we          = 1'b1;
            cmd.h_waddr       = {i_ff[VTX_W-1:0], j_ff[VTX_W-1:0]};
            cmd.h_wdata.valid = d_rd0.reach && (i_ff != j_ff);
            cmd.h_wdata.hop   = cmd.h_wdata.valid ? j_ff[VTX_W-1:0] : '0;
            state_in          = S_INIT_RD;
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  i_in     = '0;
                  state_in = S_HDR;
               end else begin
                  i_in = i_nxt;
               end
            end else begin
               j_in = j_nxt;
            end
         end
         S_HDR: begin
            cmd.d_re0    = 1'b1;
            cmd.d_raddr0 = {i_ff[VTX_W-1:0], k_ff[VTX_W-1:0]};
            cmd.h_re     = 1'b1;
            cmd.h_raddr  = {i_ff[VTX_W-1:0], k_ff[VTX_W-1:0]};
            state_in     = S_HDR2;
         end
         S_HDR2: begin
            ik_dist_in = d_rd0.cost;
            if (d_rd0.reach) begin
               cmd.d_re0    = 1'b1;
               cmd.d_raddr0 = {k_ff[VTX_W-1:0], {VTX_W{1'b0}}};
               cmd.d_re1    = 1'b1;
               cmd.d_raddr1 = {i_ff[VTX_W-1:0], {VTX_W{1'b0}}};
               j_in         = '0;
               state_in     = S_LOOP;
            end else begin
               i_in     = row_i;
               k_in     = row_k;
               state_in = row_state;
            end
         end
         S_LOOP: begin
            if (upd) begin
               cmd.d_we          = 1'b1;
               cmd.d_waddr       = {i_ff[VTX_W-1:0], j_ff[VTX_W-1:0]};
               cmd.d_wdata.cost  = sum;
               cmd.d_wdata.reach = 1'b1;
               cmd.h_we          = 1'b1;
               cmd.h_waddr       = {i_ff[VTX_W-1:0], j_ff[VTX_W-1:0]};
               cmd.h_wdata       = h_rd;
               // leg i->k itself improved: forward into the held copy
               if (j_ff == k_ff) begin
                  ik_dist_in = sum;
               end
            end
            if (last_j) begin
               i_in     = row_i;
               k_in     = row_k;
               state_in = row_state;
            end else begin
               cmd.d_re0    = 1'b1;
               cmd.d_raddr0 = {k_ff[VTX_W-1:0], j_nxt[VTX_W-1:0]};
               cmd.d_re1    = 1'b1;
               cmd.d_raddr1 = {i_ff[VTX_W-1:0], j_nxt[VTX_W-1:0]};
               j_in         = j_nxt;
            end
         end
         S_DONE: begin
            done_req = 1'b1;
            if (done_ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      ik_dist_ff <= ik_dist_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule
